// ===== hdl/ezr_pkg.sv =====
`default_nettype none
package ezr_pkg;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } ezr_in_t;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
    } ezr_out_t;

    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [17:0] ONE_Q14     = 18'sd16384;

    // atan(2^-i) in q30
    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] t;
        begin
            case (i)
                0: t = 34'sd843314857;
                1: t = 34'sd497837829;
                2: t = 34'sd263043837;
                3: t = 34'sd133525159;
                4: t = 34'sd67021687;
                5: t = 34'sd33543516;
                6: t = 34'sd16775851;
                7: t = 34'sd8388437;
                8: t = 34'sd4194283;
                9: t = 34'sd2097149;
                default: t = (i < 31) ? (34'sd1 <<< (30 - i)) : 34'sd0;
            endcase
            return t;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/euler_zyx_to_rotation_matrix.sv =====
// ZYX Euler angles (Q3.12 rad) to rotation matrix Rz(yaw)*Ry(pitch)*Rx(roll) in Q1.14.
// Fully pipelined, one item per cycle while out_ready keeps up. There are CORDIC_STAGES + 9
// register stages: five stages of scaling, reduction modulo two pi and quadrant fold, one per
// CORDIC iteration (three CORDICs side by side), a sign fix stage, two product stages and a
// round/saturate output register. A stage advances when it is empty or the next one advances,
// so a stall holds only the items that have no empty stage ahead of them.
`default_nettype none
module euler_zyx_to_rotation_matrix
    import ezr_pkg::*;
#(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 14
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire ezr_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output ezr_out_t      out_data
);

    localparam int PRE   = 4;
    localparam int DEPTH = PRE + CORDIC_STAGES + 5;

    // stage valids and a shared advance: stage k moves when k is empty or k+1 moves
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] adv;

    always_comb
    begin
        adv[DEPTH-1] = !vld_reg[DEPTH-1] || out_ready;
        for (int k = DEPTH - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < DEPTH; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // angle front end: zero extend to ANGLE_BITS, scale to q30, reduce modulo two pi
    logic signed [ANGLE_BITS-1:0] a_in [3];
    logic signed [35:0] m0_next [3];
    logic signed [35:0] m0_reg [3];
    logic signed [35:0] m1_reg [3];
    logic signed [35:0] m2_next [3];
    logic               n2_next [3];

    // scaled angle fits well beyond 36 bits for wide fields, keep it wide
    localparam int SW = ANGLE_BITS + 19;
    logic signed [SW-1:0] scaled_reg [3];
    logic [ANGLE_BITS-1:0] rawbits [3];
    always_comb
    begin
        rawbits[0] = ANGLE_BITS'({{(ANGLE_BITS > 16 ? ANGLE_BITS - 16 : 1){1'b0}}, in_data.roll_angle});
        rawbits[1] = ANGLE_BITS'({{(ANGLE_BITS > 16 ? ANGLE_BITS - 16 : 1){1'b0}}, in_data.pitch_angle});
        rawbits[2] = ANGLE_BITS'({{(ANGLE_BITS > 16 ? ANGLE_BITS - 16 : 1){1'b0}}, in_data.yaw_angle});
        for (int j = 0; j < 3; j++)
        begin
            a_in[j] = $signed(rawbits[j]);
        end
    end

    // stage 0: scale. stage 1: quotient estimate. stage 2: coarse reduction. stage 3: fine
    logic signed [SW+20:0] qprod [3];
    logic signed [20:0]    quot_next [3];
    logic signed [20:0]    quot_reg [3];
    logic signed [SW-1:0]  sc1_reg [3];
    logic signed [SW+22:0] rem_full [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            // floor(scaled / 2pi) approx: scaled>>30 times 2^24/(2pi) (2670177), then >>24
            // off by at most one period either way
            qprod[j] = $signed(scaled_reg[j] >>> 30) * $signed(24'sd2670177);
            quot_next[j] = 21'(qprod[j] >>> 24);
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            rem_full[j] = (SW+23)'(sc1_reg[j])
                        - (SW+23)'($signed(quot_reg[j])) * (SW+23)'(TWO_PI_Q30);
            m0_next[j] = 36'(rem_full[j]);
        end
    end

    logic signed [35:0] fold_a [3];
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            // bring [0, 2pi) into (-pi, pi], then fold into a half turn
            fold_a[j] = m1_reg[j];
            if (fold_a[j] > PI_Q30)
            begin
                fold_a[j] = fold_a[j] - TWO_PI_Q30;
            end
            m2_next[j] = fold_a[j];
            n2_next[j] = 1'b0;
            if (fold_a[j] > HALF_PI_Q30)
            begin
                m2_next[j] = fold_a[j] - PI_Q30;
                n2_next[j] = 1'b1;
            end
            else if (fold_a[j] < -HALF_PI_Q30)
            begin
                m2_next[j] = fold_a[j] + PI_Q30;
                n2_next[j] = 1'b1;
            end
        end
    end

    logic signed [35:0] m1_next [3];
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            // fix quotient error: land in [0, 2pi)
            m1_next[j] = m0_reg[j];
            if (m0_reg[j] < 0)
            begin
                m1_next[j] = m0_reg[j] + TWO_PI_Q30;
            end
            else if (m0_reg[j] >= TWO_PI_Q30)
            begin
                m1_next[j] = m0_reg[j] - TWO_PI_Q30;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (adv[0])
            begin
                scaled_reg[j] <= SW'(a_in[j]) <<< 18;
            end
            if (adv[1])
            begin
                sc1_reg[j]  <= scaled_reg[j];
                quot_reg[j] <= quot_next[j];
            end
            if (adv[2])
            begin
                m0_reg[j] <= m0_next[j];
            end
            if (adv[3])
            begin
                m1_reg[j] <= m1_next[j];
            end
        end
    end

    // fold happens on entry to the first cordic stage
    logic signed [33:0] cx_reg [CORDIC_STAGES+1][3];
    logic signed [33:0] cy_reg [CORDIC_STAGES+1][3];
    logic signed [33:0] cz_reg [CORDIC_STAGES+1][3];
    logic               cn_reg [CORDIC_STAGES+1][3];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (adv[PRE])
            begin
                cx_reg[0][j] <= GAIN_Q30;
                cy_reg[0][j] <= '0;
                cz_reg[0][j] <= 34'(m2_next[j]);
                cn_reg[0][j] <= n2_next[j];
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (adv[PRE+1+i])
                begin
                    cn_reg[i+1][j] <= cn_reg[i][j];
                    if (!cz_reg[i][j][33])
                    begin
                        cx_reg[i+1][j] <= cx_reg[i][j] - (cy_reg[i][j] >>> i);
                        cy_reg[i+1][j] <= cy_reg[i][j] + (cx_reg[i][j] >>> i);
                        cz_reg[i+1][j] <= cz_reg[i][j] - atan_q30(i);
                    end
                    else
                    begin
                        cx_reg[i+1][j] <= cx_reg[i][j] + (cy_reg[i][j] >>> i);
                        cy_reg[i+1][j] <= cy_reg[i][j] - (cx_reg[i][j] >>> i);
                        cz_reg[i+1][j] <= cz_reg[i][j] + atan_q30(i);
                    end
                end
            end
        end
    end

    // unused z bits after the last stage are fine; sign fix
    localparam int SC = PRE + 1 + CORDIC_STAGES;
    logic signed [31:0] s_reg [3];
    logic signed [31:0] c_reg [3];
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (adv[SC])
            begin
                s_reg[j] <= cn_reg[CORDIC_STAGES][j] ? 32'(-cy_reg[CORDIC_STAGES][j])
                                                     : 32'(cy_reg[CORDIC_STAGES][j]);
                c_reg[j] <= cn_reg[CORDIC_STAGES][j] ? 32'(-cx_reg[CORDIC_STAGES][j])
                                                     : 32'(cx_reg[CORDIC_STAGES][j]);
            end
        end
    end

    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        begin
            p = 64'(a) * 64'(b) + 64'sd536870912;
            return 32'(p >>> 30);
        end
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
        logic signed [33:0] r;
        begin
            r = (v + 34'sd32768) >>> 16;
            if (r > 34'(ONE_Q14))
            begin
                r = 34'(ONE_Q14);
            end
            if (r < -34'(ONE_Q14))
            begin
                r = -34'(ONE_Q14);
            end
            return 16'(r);
        end
    endfunction

    // products stage 1: sg cg sb cb sa ca -> index 0 roll, 1 pitch, 2 yaw
    logic signed [31:0] sbsg_reg, sbcg_reg, cacb_reg, sacb_reg, cbsg_reg, cbcg_reg;
    logic signed [31:0] sacg_reg, sasg_reg, cacg_reg, casg_reg, sa1_reg, ca1_reg, sb1_reg;
    always_ff @(posedge clk)
    begin
        if (adv[SC+1])
        begin
            sbsg_reg <= mulq(s_reg[1], s_reg[0]);
            sbcg_reg <= mulq(s_reg[1], c_reg[0]);
            cacb_reg <= mulq(c_reg[2], c_reg[1]);
            sacb_reg <= mulq(s_reg[2], c_reg[1]);
            cbsg_reg <= mulq(c_reg[1], s_reg[0]);
            cbcg_reg <= mulq(c_reg[1], c_reg[0]);
            sacg_reg <= mulq(s_reg[2], c_reg[0]);
            sasg_reg <= mulq(s_reg[2], s_reg[0]);
            cacg_reg <= mulq(c_reg[2], c_reg[0]);
            casg_reg <= mulq(c_reg[2], s_reg[0]);
            sa1_reg  <= s_reg[2];
            ca1_reg  <= c_reg[2];
            sb1_reg  <= s_reg[1];
        end
    end

    logic signed [33:0] v_reg [9];
    always_ff @(posedge clk)
    begin
        if (adv[SC+2])
        begin
            v_reg[0] <= 34'(cacb_reg);
            v_reg[1] <= 34'(mulq(ca1_reg, sbsg_reg)) - 34'(sacg_reg);
            v_reg[2] <= 34'(mulq(ca1_reg, sbcg_reg)) + 34'(sasg_reg);
            v_reg[3] <= 34'(sacb_reg);
            v_reg[4] <= 34'(mulq(sa1_reg, sbsg_reg)) + 34'(cacg_reg);
            v_reg[5] <= 34'(mulq(sa1_reg, sbcg_reg)) - 34'(casg_reg);
            v_reg[6] <= -34'(sb1_reg);
            v_reg[7] <= 34'(cbsg_reg);
            v_reg[8] <= 34'(cbcg_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[SC+3])
        begin
            out_data.r00 <= to_q14(v_reg[0]);
            out_data.r01 <= to_q14(v_reg[1]);
            out_data.r02 <= to_q14(v_reg[2]);
            out_data.r10 <= to_q14(v_reg[3]);
            out_data.r11 <= to_q14(v_reg[4]);
            out_data.r12 <= to_q14(v_reg[5]);
            out_data.r20 <= to_q14(v_reg[6]);
            out_data.r21 <= to_q14(v_reg[7]);
            out_data.r22 <= to_q14(v_reg[8]);
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ezr_checker.sv =====
`default_nettype none
module ezr_props
    import ezr_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_ready,
    input wire logic     out_valid,
    input wire logic     out_ready,
    input wire ezr_out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item dropped or changed while stalled");

    a_r20_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.r20 <= 16'sd16384 && out_data.r20 >= -16'sd16384))
        else $error("r20 out of range");

    a_r22_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.r22 <= 16'sd16384 && out_data.r22 >= -16'sd16384))
        else $error("r22 out of range");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind euler_zyx_to_rotation_matrix ezr_props u_ezr_props (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

// ===== tb/sv/ezr_checker.sv =====
module ezr_checker
    import ezr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_ready,
    input  wire ezr_in_t  in_data,
    input  wire logic     out_valid,
    input  wire logic     out_ready,
    input  wire ezr_out_t out_data,
    output int            errors,
    output int            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES = 14;

    ezr_out_t matrix_q[$];

    function automatic void cordic_sin_cos(input logic signed [15:0] ang,
                                           output longint s, output longint c);
        longint z, x, y, dx, dy, t;
        bit flip;
        z = (longint'(ang) * 262144) % longint'(TWO_PI_Q30);
        x = GAIN_Q30;
        y = 0;
        flip = 0;
        if (z < 0) z += TWO_PI_Q30;
        if (z > PI_Q30) z -= TWO_PI_Q30;
        if (z > HALF_PI_Q30)
        begin
            z -= PI_Q30;
            flip = 1;
        end
        else if (z < -HALF_PI_Q30)
        begin
            z += PI_Q30;
            flip = 1;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            case (i)
                0: t = 843314857;
                1: t = 497837829;
                2: t = 263043837;
                3: t = 133525159;
                4: t = 67021687;
                5: t = 33543516;
                6: t = 16775851;
                7: t = 8388437;
                8: t = 4194283;
                9: t = 2097149;
                default: t = longint'(1) << (30 - i);
            endcase
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= t;
            end
            else
            begin
                x += dx;
                y -= dy;
                z += t;
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic logic signed [15:0] round_q14(input longint v);
        longint r;
        r = (v + (longint'(1) << 15)) >>> 16;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    function automatic ezr_out_t rotation_of(input ezr_in_t a);
        longint sg, cg, sb, cb, sa, ca, sbsg, sbcg;
        ezr_out_t m;
        cordic_sin_cos(a.roll_angle, sg, cg);
        cordic_sin_cos(a.pitch_angle, sb, cb);
        cordic_sin_cos(a.yaw_angle, sa, ca);
        sbsg = mul_q30(sb, sg);
        sbcg = mul_q30(sb, cg);
        m.r00 = round_q14(mul_q30(ca, cb));
        m.r01 = round_q14(mul_q30(ca, sbsg) - mul_q30(sa, cg));
        m.r02 = round_q14(mul_q30(ca, sbcg) + mul_q30(sa, sg));
        m.r10 = round_q14(mul_q30(sa, cb));
        m.r11 = round_q14(mul_q30(sa, sbsg) + mul_q30(ca, cg));
        m.r12 = round_q14(mul_q30(sa, sbcg) - mul_q30(ca, sg));
        m.r20 = round_q14(-sb);
        m.r21 = round_q14(mul_q30(cb, sg));
        m.r22 = round_q14(mul_q30(cb, cg));
        return m;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        errors++;
    endtask

    initial errors = 0;
    assign pending = matrix_q.size();

    always @(posedge clk)
    begin
        ezr_out_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                matrix_q.push_back(rotation_of(in_data));
            if (out_valid && out_ready)
            begin
                if (matrix_q.size() == 0)
                    report("unexpected item", 0, 0);
                else
                begin
                    want = matrix_q.pop_front();
                    if (out_data.r00 !== want.r00) report("r00", out_data.r00, want.r00);
                    if (out_data.r01 !== want.r01) report("r01", out_data.r01, want.r01);
                    if (out_data.r02 !== want.r02) report("r02", out_data.r02, want.r02);
                    if (out_data.r10 !== want.r10) report("r10", out_data.r10, want.r10);
                    if (out_data.r11 !== want.r11) report("r11", out_data.r11, want.r11);
                    if (out_data.r12 !== want.r12) report("r12", out_data.r12, want.r12);
                    if (out_data.r20 !== want.r20) report("r20", out_data.r20, want.r20);
                    if (out_data.r21 !== want.r21) report("r21", out_data.r21, want.r21);
                    if (out_data.r22 !== want.r22) report("r22", out_data.r22, want.r22);
                end
            end
        end
    end
endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import ezr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic     clk = 0;
    logic     rst_n = 0;
    logic     in_valid = 0;
    logic     in_ready;
    ezr_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 0;
    ezr_out_t out_data;
    int       errors, pending;
    int       send_idle = 0, recv_stall = 0;

    always #10 clk = ~clk;

    euler_zyx_to_rotation_matrix dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    ezr_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .errors(errors), .pending(pending)
    );

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall);

    task automatic send(input ezr_in_t a);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data  <= a;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // random angles, or with one chance in four an angle near a multiple of pi/2 or a field extreme
    function automatic logic signed [15:0] pick_angle();
        logic signed [15:0] pts[10] = '{16'sh8000, 16'sh7fff, 0, 1, -1,
            6434, -6434, 12868, -12868, 25736};
        case ($urandom_range(3))
            0: return 16'(pts[$urandom_range(9)] + $signed(16'($urandom_range(6))) - 16'sd3);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic signed [15:0] dir[14];
        ezr_in_t a;
        dir = '{0, 1, -1, 16'sh7fff, 16'sh8000,
            6434, 6435, -6434, -6435, 12868, -12868, 3217, 25736, 16'h5555};
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (dir[i])
        begin
            a = '{dir[i], dir[(i + 5) % 14], dir[(i + 9) % 14]};
            send(a);
        end
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle  = (ph == 1 || ph == 3) ? (ph == 3 ? 10 : 78) : 0;
            recv_stall = (ph == 2 || ph == 3) ? (ph == 3 ? 10 : 78) : 0;
            for (int n = 0; n < 400; n++)
            begin
                a = '{pick_angle(), pick_angle(), pick_angle()};
                send(a);
                if (n == 200)
                begin
                    in_valid <= 0;
                    @(posedge clk);
                    while (pending != 0) @(posedge clk);
                end
            end
        end
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end
endmodule
